[src/status_led_event_renderer_defines.svh]
// Assertion macros shared by the status LED event renderer modules.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef STATUS_LED_EVENT_RENDERER_DEFINES_SVH
`define STATUS_LED_EVENT_RENDERER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLER_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("status LED renderer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLER_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("status LED renderer check failed");

`endif

[src/sler_pkg.sv]
// Shared types, codes and constants of the status LED event renderer.
// Used by the controller, the datapath and the top level; no dependencies.
package sler_pkg;

    localparam int NUM_LEDS  = 3;
    localparam int LED_W     = 4;
    localparam int COLOR_W   = 24;
    localparam int CH_W      = 8;
    localparam int TIME_W    = 12;
    localparam int COUNT_W   = 3;
    localparam int SLOT_W    = 8;
    localparam int REQ_W     = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [REQ_W-1:0] REQ_SUCCESS    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_FAILURE    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_EDIT_BEGIN = 3'd2;
    localparam logic [REQ_W-1:0] REQ_EDIT_END   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SLOT_SEL   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_SLOT_CLR   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_EDIT_COLOR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SELECT_COLOR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUCCESS_COLOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAILURE_COLOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_COUNT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_ON      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_OFF     = 3'd6;

    localparam logic [COLOR_W-1:0] RST_EDIT_COLOR    = 24'h8C00B4;
    localparam logic [COLOR_W-1:0] RST_SELECT_COLOR  = 24'h0000FF;
    localparam logic [COLOR_W-1:0] RST_SUCCESS_COLOR = 24'h00FF00;
    localparam logic [COLOR_W-1:0] RST_FAILURE_COLOR = 24'hFF0000;
    localparam logic [COUNT_W-1:0] RST_FLASH_COUNT   = 3'd3;
    localparam logic [TIME_W-1:0]  RST_FLASH_ON      = 12'd140;
    localparam logic [TIME_W-1:0]  RST_FLASH_OFF     = 12'd120;
    localparam logic [SLOT_W-1:0]  NO_SLOT           = 8'd255;

    localparam logic [LED_W-1:0]  LED_LAST_IDX = LED_W'(NUM_LEDS - 1);
    localparam logic [SLOT_W-1:0] SLOT_LIMIT   = SLOT_W'(NUM_LEDS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLASH_ON,
        ST_FLASH_OFF,
        ST_REST
    } state_t;

    typedef enum logic [1:0] {
        FR_ON,
        FR_OFF,
        FR_REST
    } frame_kind_t;

    typedef struct packed {
        logic        load;
        logic        step;
        frame_kind_t kind;
    } sler_cmd_t;

    typedef struct packed {
        logic flash_go;
        logic led_last;
        logic pair_last;
        logic out_free;
    } sler_stat_t;

endpackage

[src/sler_ctrl.sv]
// Sequencing state machine of the status LED event renderer.
// Depends on sler_pkg and the assertion macros in the defines header.
`include "status_led_event_renderer_defines.svh"

module sler_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sler_pkg::sler_stat_t stat,
    output sler_pkg::sler_cmd_t  cmd
);
    import sler_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = stat.flash_go ? ST_FLASH_ON : ST_REST;
                end
            end
            ST_FLASH_ON: begin
                if (cmd.step && stat.led_last) begin
                    state_next = ST_FLASH_OFF;
                end
            end
            ST_FLASH_OFF: begin
                if (cmd.step && stat.led_last) begin
                    state_next = stat.pair_last ? ST_REST : ST_FLASH_ON;
                end
            end
            ST_REST: begin
                if (cmd.step && stat.led_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        emit     = 1'b0;
        cmd.kind = FR_REST;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_FLASH_ON: begin
                emit     = 1'b1;
                cmd.kind = FR_ON;
            end
            ST_FLASH_OFF: begin
                emit     = 1'b1;
                cmd.kind = FR_OFF;
            end
            ST_REST: begin
                emit     = 1'b1;
                cmd.kind = FR_REST;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
        cmd.load = s_ready && s_valid;
        cmd.step = emit && stat.out_free;
    end

    `SLER_ASSERT_NEXT(a_load_leaves_idle, aclk, aresetn, cmd.load, state_reg != ST_IDLE)
    `SLER_ASSERT_NEXT(a_rest_end_idle, aclk, aresetn,
                      cmd.step && stat.led_last && state_reg == ST_REST, state_reg == ST_IDLE)
    `SLER_ASSERT_NOW(a_no_step_idle, aclk, aresetn, state_reg == ST_IDLE, !cmd.step)

endmodule

[src/sler_datapath.sv]
// Datapath of the status LED event renderer: settings, marks, counters, output register.
// Depends on sler_pkg and the assertion macros in the defines header.
`include "status_led_event_renderer_defines.svh"

module sler_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [sler_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [sler_pkg::COLOR_W-1:0]        cfg_wdata,
    input  logic [sler_pkg::REQ_W-1:0]          s_req_type,
    input  logic [sler_pkg::SLOT_W-1:0]         s_slot,
    input  sler_pkg::sler_cmd_t                 cmd,
    output sler_pkg::sler_stat_t                stat,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [sler_pkg::LED_W-1:0]          m_led_index,
    output logic [sler_pkg::CH_W-1:0]           m_red,
    output logic [sler_pkg::CH_W-1:0]           m_green,
    output logic [sler_pkg::CH_W-1:0]           m_blue,
    output logic [sler_pkg::TIME_W-1:0]         m_hold_time,
    output logic                                m_frame_end,
    output logic                                m_last
);
    import sler_pkg::*;

    logic [COLOR_W-1:0] edit_color_reg;
    logic [COLOR_W-1:0] select_color_reg;
    logic [COLOR_W-1:0] success_color_reg;
    logic [COLOR_W-1:0] failure_color_reg;
    logic [COUNT_W-1:0] flash_count_reg;
    logic [TIME_W-1:0]  flash_on_reg;
    logic [TIME_W-1:0]  flash_off_reg;

    logic               edit_on_reg;
    logic [SLOT_W-1:0]  edit_target_reg;
    logic               select_on_reg;
    logic [SLOT_W-1:0]  select_target_reg;
    logic               success_reg;

    logic [LED_W-1:0]   led_cnt_reg;
    logic [COUNT_W-1:0] pair_cnt_reg;

    logic               m_valid_reg;
    logic               m_valid_next;
    logic [LED_W-1:0]   led_index_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [TIME_W-1:0]  hold_reg;
    logic               frame_end_reg;
    logic               last_reg;

    logic [COLOR_W-1:0] color_next;
    logic [TIME_W-1:0]  hold_next;
    logic [COLOR_W-1:0] rest_color;
    logic [SLOT_W-1:0]  rest_target;
    logic               rest_any;
    logic               rest_lit;
    logic               req_is_flash;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edit_color_reg    <= RST_EDIT_COLOR;
            select_color_reg  <= RST_SELECT_COLOR;
            success_color_reg <= RST_SUCCESS_COLOR;
            failure_color_reg <= RST_FAILURE_COLOR;
            flash_count_reg   <= RST_FLASH_COUNT;
            flash_on_reg      <= RST_FLASH_ON;
            flash_off_reg     <= RST_FLASH_OFF;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_EDIT_COLOR:    edit_color_reg    <= cfg_wdata;
                REG_SELECT_COLOR:  select_color_reg  <= cfg_wdata;
                REG_SUCCESS_COLOR: success_color_reg <= cfg_wdata;
                REG_FAILURE_COLOR: failure_color_reg <= cfg_wdata;
                REG_FLASH_COUNT:   flash_count_reg   <= cfg_wdata[COUNT_W-1:0];
                REG_FLASH_ON:      flash_on_reg      <= cfg_wdata[TIME_W-1:0];
                REG_FLASH_OFF:     flash_off_reg     <= cfg_wdata[TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign req_is_flash = (s_req_type == REQ_SUCCESS) || (s_req_type == REQ_FAILURE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edit_on_reg       <= 1'b0;
            edit_target_reg   <= NO_SLOT;
            select_on_reg     <= 1'b0;
            select_target_reg <= NO_SLOT;
        end else if (cmd.load) begin
            case (s_req_type)
                REQ_SUCCESS, REQ_FAILURE, REQ_SLOT_CLR: begin
                    select_on_reg     <= 1'b0;
                    select_target_reg <= NO_SLOT;
                end
                REQ_EDIT_BEGIN: begin
                    edit_on_reg     <= 1'b1;
                    edit_target_reg <= s_slot;
                end
                REQ_EDIT_END: begin
                    edit_on_reg     <= 1'b0;
                    edit_target_reg <= NO_SLOT;
                end
                REQ_SLOT_SEL: begin
                    select_on_reg     <= 1'b1;
                    select_target_reg <= s_slot;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            success_reg <= (s_req_type == REQ_SUCCESS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_cnt_reg  <= '0;
            pair_cnt_reg <= '0;
        end else if (cmd.load) begin
            led_cnt_reg  <= '0;
            pair_cnt_reg <= '0;
        end else if (cmd.step) begin
            led_cnt_reg <= stat.led_last ? '0 : led_cnt_reg + 1'b1;
            if (stat.led_last && cmd.kind == FR_OFF) begin
                pair_cnt_reg <= pair_cnt_reg + 1'b1;
            end
        end
    end

    always_comb begin
        stat.flash_go  = req_is_flash && (flash_count_reg != '0);
        stat.led_last  = (led_cnt_reg == LED_LAST_IDX);
        stat.pair_last = ({1'b0, pair_cnt_reg} + 1'b1) == {1'b0, flash_count_reg};
        stat.out_free  = !m_valid_reg || m_ready;
    end

    always_comb begin
        if (edit_on_reg) begin
            rest_color  = edit_color_reg;
            rest_target = edit_target_reg;
            rest_any    = 1'b1;
        end else if (select_on_reg) begin
            rest_color  = select_color_reg;
            rest_target = select_target_reg;
            rest_any    = 1'b1;
        end else begin
            rest_color  = '0;
            rest_target = NO_SLOT;
            rest_any    = 1'b0;
        end
        rest_lit = rest_any && (rest_target < SLOT_LIMIT)
                   && (rest_target == {{(SLOT_W-LED_W){1'b0}}, led_cnt_reg});
        case (cmd.kind)
            FR_ON: begin
                color_next = success_reg ? success_color_reg : failure_color_reg;
                hold_next  = flash_on_reg;
            end
            FR_OFF: begin
                color_next = '0;
                hold_next  = flash_off_reg;
            end
            default: begin
                color_next = rest_lit ? rest_color : '0;
                hold_next  = '0;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.step) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            led_index_reg <= led_cnt_reg;
            color_reg     <= color_next;
            hold_reg      <= hold_next;
            frame_end_reg <= stat.led_last;
            last_reg      <= stat.led_last && (cmd.kind == FR_REST);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_led_index = led_index_reg;
    assign m_red       = color_reg[COLOR_W-1 -: CH_W];
    assign m_green     = color_reg[CH_W +: CH_W];
    assign m_blue      = color_reg[CH_W-1:0];
    assign m_hold_time = hold_reg;
    assign m_frame_end = frame_end_reg;
    assign m_last      = last_reg;

    `SLER_ASSERT_NOW(a_last_ends_frame, aclk, aresetn, m_valid_reg && last_reg, frame_end_reg)
    `SLER_ASSERT_NEXT(a_load_clears_led, aclk, aresetn, cmd.load, led_cnt_reg == '0)
    `SLER_ASSERT_NEXT(a_valid_held, aclk, aresetn, m_valid_reg && !m_ready, m_valid_reg)

endmodule

[src/status_led_event_renderer.sv]
// Status LED event renderer: one event in, a sequence of per-LED frame results out.
// A flash event gives (2*flash_count+1)*NUM_LEDS results and any other event NUM_LEDS,
// set by the frame sequencer and LED counter; one result per cycle while m_ready does not
// stall the output, and no new event is taken while a sequence runs.
// Reset (aresetn low, synchronous) restores register defaults, clears marks and output.
// Depends on sler_pkg, sler_ctrl and sler_datapath.
module status_led_event_renderer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [sler_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [sler_pkg::COLOR_W-1:0]    cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [sler_pkg::REQ_W-1:0]      s_req_type,
    input  logic [sler_pkg::SLOT_W-1:0]     s_slot,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [sler_pkg::LED_W-1:0]      m_led_index,
    output logic [sler_pkg::CH_W-1:0]       m_red,
    output logic [sler_pkg::CH_W-1:0]       m_green,
    output logic [sler_pkg::CH_W-1:0]       m_blue,
    output logic [sler_pkg::TIME_W-1:0]     m_hold_time,
    output logic                            m_frame_end,
    output logic                            m_last
);
    import sler_pkg::*;

    sler_cmd_t  cmd;
    sler_stat_t stat;

    sler_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sler_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_req_type  (s_req_type),
        .s_slot      (s_slot),
        .cmd         (cmd),
        .stat        (stat),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_led_index (m_led_index),
        .m_red       (m_red),
        .m_green     (m_green),
        .m_blue      (m_blue),
        .m_hold_time (m_hold_time),
        .m_frame_end (m_frame_end),
        .m_last      (m_last)
    );

endmodule

[verif/sler_checker.sv]
`timescale 1ns / 100ps
// Result checker for the status LED event renderer: tracks register writes and event
// transfers, predicts every per-LED frame result and compares each result transfer.
// Depends on sler_pkg only.
module sler_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [sler_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [sler_pkg::COLOR_W-1:0]   cfg_wdata,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [sler_pkg::REQ_W-1:0]     s_req_type,
    input  logic [sler_pkg::SLOT_W-1:0]    s_slot,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [sler_pkg::LED_W-1:0]     m_led_index,
    input  logic [sler_pkg::CH_W-1:0]      m_red,
    input  logic [sler_pkg::CH_W-1:0]      m_green,
    input  logic [sler_pkg::CH_W-1:0]      m_blue,
    input  logic [sler_pkg::TIME_W-1:0]    m_hold_time,
    input  logic                           m_frame_end,
    input  logic                           m_last,
    output int                             mismatches,
    output int                             frames_pending
);
    import sler_pkg::*;

    typedef struct packed {
        logic [LED_W-1:0]  led_index;
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   blue;
        logic [TIME_W-1:0] hold_time;
        logic              frame_end;
        logic              event_done;
    } led_result_t;

    led_result_t frames_due[$];
    int fail_count = 0;

    logic [COLOR_W-1:0] edit_rgb;
    logic [COLOR_W-1:0] select_rgb;
    logic [COLOR_W-1:0] success_rgb;
    logic [COLOR_W-1:0] failure_rgb;
    logic [COUNT_W-1:0] pair_count;
    logic [TIME_W-1:0]  on_ms;
    logic [TIME_W-1:0]  off_ms;
    logic               editing;
    logic [SLOT_W-1:0]  edit_mark;
    logic               selecting;
    logic [SLOT_W-1:0]  select_slot;

    // A lit position of NUM_LEDS lights every LED; anything above lights none.
    task automatic add_frame(input logic [COLOR_W-1:0] rgb, input int lit,
                             input logic [TIME_W-1:0] hold, input logic closes_event);
        led_result_t r;
        logic [COLOR_W-1:0] c;
        for (int i = 0; i < NUM_LEDS; i++) begin
            c = (lit == NUM_LEDS || lit == i) ? rgb : '0;
            r.led_index  = LED_W'(i);
            r.red        = c[23:16];
            r.green      = c[15:8];
            r.blue       = c[7:0];
            r.hold_time  = hold;
            r.frame_end  = (i == NUM_LEDS - 1);
            r.event_done = closes_event && (i == NUM_LEDS - 1);
            frames_due.push_back(r);
        end
    endtask

    task automatic render_event(input logic [REQ_W-1:0] req, input logic [SLOT_W-1:0] slot);
        logic [COLOR_W-1:0] flash_rgb;
        case (req)
            REQ_SUCCESS, REQ_FAILURE: begin
                flash_rgb = (req == REQ_SUCCESS) ? success_rgb : failure_rgb;
                selecting = 1'b0;
                select_slot = NO_SLOT;
                for (int k = 0; k < pair_count; k++) begin
                    add_frame(flash_rgb, NUM_LEDS, on_ms, 1'b0);
                    add_frame('0, NUM_LEDS + 1, off_ms, 1'b0);
                end
            end
            REQ_EDIT_BEGIN: begin
                editing = 1'b1;
                edit_mark = slot;
            end
            REQ_EDIT_END: begin
                editing = 1'b0;
                edit_mark = NO_SLOT;
            end
            REQ_SLOT_SEL: begin
                selecting = 1'b1;
                select_slot = slot;
            end
            REQ_SLOT_CLR: begin
                selecting = 1'b0;
                select_slot = NO_SLOT;
            end
            default: ;
        endcase
        if (editing) begin
            add_frame(edit_rgb, (edit_mark < NUM_LEDS) ? int'(edit_mark) : NUM_LEDS + 1,
                      '0, 1'b1);
        end else if (selecting) begin
            add_frame(select_rgb, (select_slot < NUM_LEDS) ? int'(select_slot) : NUM_LEDS + 1,
                      '0, 1'b1);
        end else begin
            add_frame('0, NUM_LEDS + 1, '0, 1'b1);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        led_result_t want;
        if (!aresetn) begin
            edit_rgb    = RST_EDIT_COLOR;
            select_rgb  = RST_SELECT_COLOR;
            success_rgb = RST_SUCCESS_COLOR;
            failure_rgb = RST_FAILURE_COLOR;
            pair_count  = RST_FLASH_COUNT;
            on_ms       = RST_FLASH_ON;
            off_ms      = RST_FLASH_OFF;
            editing     = 1'b0;
            edit_mark   = NO_SLOT;
            selecting   = 1'b0;
            select_slot = NO_SLOT;
            frames_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_EDIT_COLOR:    edit_rgb = cfg_wdata;
                    REG_SELECT_COLOR:  select_rgb = cfg_wdata;
                    REG_SUCCESS_COLOR: success_rgb = cfg_wdata;
                    REG_FAILURE_COLOR: failure_rgb = cfg_wdata;
                    REG_FLASH_COUNT:   pair_count = cfg_wdata[COUNT_W-1:0];
                    REG_FLASH_ON:      on_ms = cfg_wdata[TIME_W-1:0];
                    REG_FLASH_OFF:     off_ms = cfg_wdata[TIME_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                render_event(s_req_type, s_slot);
            end
            if (m_valid && m_ready) begin
                if (frames_due.size() == 0) begin
                    $display("%0t: result transfer with none expected, actual led %0d rgb %h%h%h",
                             $time, m_led_index, m_red, m_green, m_blue);
                    fail_count++;
                end else begin
                    want = frames_due.pop_front();
                    check_field("led_index", want.led_index, m_led_index);
                    check_field("red", want.red, m_red);
                    check_field("green", want.green, m_green);
                    check_field("blue", want.blue, m_blue);
                    check_field("hold_time", want.hold_time, m_hold_time);
                    check_field("frame_end", want.frame_end, m_frame_end);
                    check_field("last", want.event_done, m_last);
                end
            end
        end
        frames_pending <= frames_due.size();
        mismatches <= fail_count;
    end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Top of the status LED event renderer testbench: clock, reset, register writes and
// event stimulus under several idle and stall mixes, plus the verdict.
// Depends on sler_pkg, sler_checker and status_led_event_renderer.
module tb_top;
    import sler_pkg::*;

    localparam logic [REQ_W-1:0] REQ_RSVD_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD_7 = 3'd7;
    localparam int QUIET_LIMIT = 4000;
    localparam int EVENTS_PER_PHASE = 80;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [COLOR_W-1:0]   cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [REQ_W-1:0]     s_req_type = '0;
    logic [SLOT_W-1:0]    s_slot = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [LED_W-1:0]     m_led_index;
    logic [CH_W-1:0]      m_red;
    logic [CH_W-1:0]      m_green;
    logic [CH_W-1:0]      m_blue;
    logic [TIME_W-1:0]    m_hold_time;
    logic                 m_frame_end;
    logic                 m_last;

    int mismatches;
    int frames_pending;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int quiet_cycles = 0;

    status_led_event_renderer u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type), .s_slot(s_slot),
        .m_valid(m_valid), .m_ready(m_ready), .m_led_index(m_led_index),
        .m_red(m_red), .m_green(m_green), .m_blue(m_blue), .m_hold_time(m_hold_time),
        .m_frame_end(m_frame_end), .m_last(m_last)
    );

    sler_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type), .s_slot(s_slot),
        .m_valid(m_valid), .m_ready(m_ready), .m_led_index(m_led_index),
        .m_red(m_red), .m_green(m_green), .m_blue(m_blue), .m_hold_time(m_hold_time),
        .m_frame_end(m_frame_end), .m_last(m_last),
        .mismatches(mismatches), .frames_pending(frames_pending)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Leaves the write enable high so back-to-back writes never toggle it within a step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic program_regs(input logic [COLOR_W-1:0] edit_c, input logic [COLOR_W-1:0] sel_c,
                                input logic [COLOR_W-1:0] succ_c, input logic [COLOR_W-1:0] fail_c,
                                input logic [COUNT_W-1:0] pairs, input logic [TIME_W-1:0] on_t,
                                input logic [TIME_W-1:0] off_t);
        write_reg(REG_EDIT_COLOR, edit_c);
        write_reg(REG_SELECT_COLOR, sel_c);
        write_reg(REG_SUCCESS_COLOR, succ_c);
        write_reg(REG_FAILURE_COLOR, fail_c);
        write_reg(REG_FLASH_COUNT, COLOR_W'(pairs));
        write_reg(REG_FLASH_ON, COLOR_W'(on_t));
        write_reg(REG_FLASH_OFF, COLOR_W'(off_t));
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [COLOR_W-1:0] rand_color();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            default: return COLOR_W'($urandom);
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] rand_hold();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return TIME_W'($urandom_range(4095));
        endcase
    endfunction

    task automatic send_event(input logic [REQ_W-1:0] req, input logic [SLOT_W-1:0] slot);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= req;
        s_slot <= slot;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (frames_pending != 0);
    endtask

    initial begin
        int src_mix[4];
        int sink_mix[4];
        int pick;
        logic [REQ_W-1:0] req;
        logic [SLOT_W-1:0] slot;

        src_mix = '{0, 83, 0, 27};
        sink_mix = '{0, 0, 83, 27};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Register defaults after reset.
        src_idle_pct = 27;
        sink_stall_pct = 27;
        send_event(REQ_SUCCESS, 8'd0);
        send_event(REQ_FAILURE, 8'hFF);
        send_event(REQ_EDIT_BEGIN, 8'd0);
        send_event(REQ_SLOT_SEL, 8'd2);
        send_event(REQ_EDIT_BEGIN, 8'd2);
        send_event(REQ_EDIT_BEGIN, 8'd3);
        send_event(REQ_EDIT_BEGIN, 8'hFF);
        send_event(REQ_EDIT_END, 8'd0);
        send_event(REQ_SUCCESS, 8'd1);
        send_event(REQ_SLOT_SEL, 8'd1);
        send_event(REQ_RSVD_6, 8'd1);
        send_event(REQ_RSVD_7, 8'hFE);
        send_event(REQ_SLOT_SEL, 8'hAA);
        send_event(REQ_SLOT_CLR, 8'd2);
        send_event(REQ_EDIT_BEGIN, 8'd1);
        send_event(REQ_FAILURE, 8'd0);
        send_event(REQ_EDIT_END, 8'h55);
        drain_results();

        program_regs('1, '1, '1, '1, '1, '1, '1);
        send_event(REQ_SUCCESS, 8'd0);
        send_event(REQ_SLOT_SEL, 8'd0);
        send_event(REQ_EDIT_BEGIN, 8'd1);
        send_event(REQ_FAILURE, 8'd2);
        drain_results();

        // A zero flash count leaves only the resting frame.
        program_regs('0, '0, '0, '0, '0, '0, '0);
        send_event(REQ_SUCCESS, 8'd0);
        send_event(REQ_EDIT_END, 8'd0);
        send_event(REQ_FAILURE, 8'd0);
        drain_results();

        program_regs(rand_color(), rand_color(), rand_color(), rand_color(), 3'd7, '0, '0);
        send_event(REQ_SUCCESS, 8'd2);
        drain_results();

        for (int p = 0; p < 4; p++) begin
            src_idle_pct = src_mix[p];
            sink_stall_pct = sink_mix[p];
            program_regs(rand_color(), rand_color(), rand_color(), rand_color(),
                         COUNT_W'($urandom_range(7)), rand_hold(), rand_hold());
            for (int n = 0; n < EVENTS_PER_PHASE; n++) begin
                pick = $urandom_range(99);
                if (pick < 14) begin
                    req = REQ_SUCCESS;
                end else if (pick < 26) begin
                    req = REQ_FAILURE;
                end else if (pick < 42) begin
                    req = REQ_EDIT_BEGIN;
                end else if (pick < 54) begin
                    req = REQ_EDIT_END;
                end else if (pick < 74) begin
                    req = REQ_SLOT_SEL;
                end else if (pick < 90) begin
                    req = REQ_SLOT_CLR;
                end else if (pick < 95) begin
                    req = REQ_RSVD_6;
                end else begin
                    req = REQ_RSVD_7;
                end
                if ($urandom_range(3) == 0) begin
                    slot = SLOT_W'($urandom);
                end else begin
                    slot = SLOT_W'($urandom_range(NUM_LEDS - 1));
                end
                send_event(req, slot);
                if ($urandom_range(29) == 0) begin
                    drain_results();
                end
            end
            drain_results();
        end

        repeat (8) @(posedge aclk);
        if (mismatches == 0 && frames_pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
